>>> rtl/lob_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_pkg
// shared types and codes of the limit order book unit
// ----------------------------------------------------------------------------
package lob_pkg;

    localparam int DATA_W = 32;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic CFG_LOWEST  = 1'b0;
    localparam logic CFG_HIGHEST = 1'b1;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_CHK,
        S_SCAN,
        S_SCAN_END,
        S_ADD_RD,
        S_ADD_WR,
        S_ADD_RT,
        S_ADD_WT,
        S_RM_RP,
        S_RM_WP,
        S_RM_RN,
        S_RM_WN,
        S_RM_RL,
        S_RM_WL,
        S_SRCH_RD,
        S_SRCH_CK,
        S_RPT_BL,
        S_RPT_BS,
        S_RPT_AL,
        S_RPT_AS,
        S_RPT_CAP,
        S_OUT
    } t_state;

endpackage

>>> rtl/lob_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lob_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/limit_order_book_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_book_unit
// price level fifo order book, bid and ask sides, one command per beat
// ----------------------------------------------------------------------------
// Commands are handled one at a time. After reset a clearing pass writes every
// entry of the level memory, with o_ready low. Every add, remove and look up
// sweeps the slot memory once to match the id and find the lowest free slot. An
// add then writes the level word and the new slot and, if the level held orders,
// links the old tail to the new order. A remove that finds its order relinks
// its neighbours and rewrites the level word. When a remove empties the best
// level of its side, a search walks the level memory one level at a time until
// the next active level. Every command ends with a report pass that fetches the
// head orders of the best levels, then the result beat is held until taken. An
// add with an out of range price and the unused command skip the sweep.
// Configuration writes are always taken and must only come while idle.
module limit_order_book_unit #(
    parameter int NUM_LEVELS = 1024,
    parameter int MAX_ORDERS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // command beat
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_order_id,
    input  logic [31:0] i_order_price,
    input  logic [31:0] i_order_qty,
    input  logic        i_order_side,
    // result beat
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_bid_valid,
    output logic [31:0] o_bid_price,
    output logic [31:0] o_bid_id,
    output logic [31:0] o_bid_qty,
    output logic        o_ask_valid,
    output logic [31:0] o_ask_price,
    output logic [31:0] o_ask_id,
    output logic [31:0] o_ask_qty,
    output logic        o_found_side,
    output logic [31:0] o_found_price,
    output logic [31:0] o_found_qty
);

    localparam int DW  = lob_pkg::DATA_W;
    localparam int LW  = $clog2(NUM_LEVELS);          // level index
    localparam int SW  = $clog2(MAX_ORDERS + 1);      // slot link incl. empty marker
    localparam int IW  = $clog2(MAX_ORDERS);          // slot address
    localparam int LAW = LW + 1;                      // {side, level}
    localparam int LDEPTH = 2 ** LAW;

    // slot word {id, level, qty, side, next, prev}
    localparam int PRV_LO = 0;
    localparam int NXT_LO = SW;
    localparam int SIDE_B = 2 * SW;
    localparam int QTY_LO = SIDE_B + 1;
    localparam int LVL_LO = QTY_LO + DW;
    localparam int ID_LO  = LVL_LO + LW;
    localparam int SLW    = ID_LO + DW;

    // level word {active, head, tail}
    localparam int LVW    = 2 * SW + 1;

    localparam logic [SW-1:0] NO_SLOT  = SW'(MAX_ORDERS);
    localparam logic [LW-1:0] TOP_LVL  = LW'(NUM_LEVELS - 1);
    localparam logic [LW-1:0] ZERO_LVL = '0;

    lob_pkg::t_state r_state, n_state;

    // configuration registers
    logic [DW-1:0] r_lo, r_hi;

    // captured command
    logic [1:0]    r_cmd;
    logic [DW-1:0] r_id, r_price, r_qty;
    logic          r_side;
    logic [LW-1:0] r_lvl;

    // sweep state
    logic [SW-1:0] r_scan, r_scan_d;
    logic          r_scan_v;
    logic          r_ffound, r_match;
    logic [IW-1:0] r_free, r_ms;
    logic [SLW-1:0] r_m;
    logic [IW-1:0] r_t;

    logic [MAX_ORDERS-1:0] r_in_use;
    logic [LAW-1:0] r_clr;

    // best levels per side
    logic          r_bv, r_av;
    logic [LW-1:0] r_bl, r_al, r_sidx;

    logic [DW-1:0] r_bid_id, r_bid_qty;
    logic [2:0]    r_status;

    // result register
    logic [2:0]    r_o_status;
    logic          r_o_bv, r_o_av, r_o_fs;
    logic [DW-1:0] r_o_bp, r_o_bi, r_o_bq, r_o_ap, r_o_ai, r_o_aq, r_o_fp, r_o_fq;

    // memory ports
    logic           l_we, s_we;
    logic [LAW-1:0] l_wa, l_ra;
    logic [LVW-1:0] l_wd, l_rd;
    logic [IW-1:0]  s_wa, s_ra;
    logic [SLW-1:0] s_wd, s_rd;

    lob_ram #(.WIDTH(LVW), .DEPTH(LDEPTH)) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_wa),
        .i_wdata (l_wd),
        .i_raddr (l_ra),
        .o_rdata (l_rd)
    );

    lob_ram #(.WIDTH(SLW), .DEPTH(MAX_ORDERS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_wa),
        .i_wdata (s_wd),
        .i_raddr (s_ra),
        .o_rdata (s_rd)
    );

    // fields of the level word just read
    logic          l_act;
    logic [SW-1:0] l_head, l_tail;
    assign l_act  = l_rd[2*SW];
    assign l_head = l_rd[2*SW-1:SW];
    assign l_tail = l_rd[SW-1:0];

    // fields of the matched slot
    logic [SW-1:0] m_prv, m_nxt;
    logic          m_side;
    logic [LW-1:0] m_lvl;
    logic [DW-1:0] m_qty;
    assign m_prv  = r_m[NXT_LO-1:PRV_LO];
    assign m_nxt  = r_m[SIDE_B-1:NXT_LO];
    assign m_side = r_m[SIDE_B];
    assign m_qty  = r_m[LVL_LO-1:QTY_LO];
    assign m_lvl  = r_m[ID_LO-1:LVL_LO];

    // price range check of an add
    logic [DW-1:0] price_off;
    logic          in_range;
    assign price_off = r_price - r_lo;
    assign in_range  = (r_price >= r_lo) && (r_price <= r_hi) &&
                       (price_off < DW'(NUM_LEVELS));

    // remove: relinked head and tail of the level
    logic [SW-1:0] rm_head, rm_tail;
    logic          rm_empty;
    assign rm_head  = (m_prv < NO_SLOT) ? l_head : m_nxt;
    assign rm_tail  = (m_nxt < NO_SLOT) ? l_tail : m_prv;
    assign rm_empty = !(rm_head < NO_SLOT);

    // add: level had no list yet
    logic add_fresh;
    assign add_fresh = !l_act || !(l_tail < NO_SLOT);

    logic scan_live;
    assign scan_live = r_scan < NO_SLOT;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == lob_pkg::S_IDLE);
    assign o_valid     = (r_state == lob_pkg::S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lob_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory control
    always_comb begin
        n_state = r_state;
        l_we = 1'b0;
        l_wa = '0;
        l_wd = '0;
        l_ra = '0;
        s_we = 1'b0;
        s_wa = '0;
        s_wd = '0;
        s_ra = '0;
        case (r_state)
            lob_pkg::S_CLR: begin
                l_we = 1'b1;
                l_wa = r_clr;
                l_wd = {1'b0, NO_SLOT, NO_SLOT};
                if (&r_clr) begin
                    n_state = lob_pkg::S_IDLE;
                end
            end
            lob_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = lob_pkg::S_CHK;
                end
            end
            lob_pkg::S_CHK: begin
                if (r_cmd == lob_pkg::CMD_ADD && !in_range) begin
                    n_state = lob_pkg::S_RPT_BL;
                end else if (r_cmd == lob_pkg::CMD_ADD || r_cmd == lob_pkg::CMD_REMOVE ||
                             r_cmd == lob_pkg::CMD_LOOKUP) begin
                    n_state = lob_pkg::S_SCAN;
                end else begin
                    n_state = lob_pkg::S_RPT_BL;
                end
            end
            lob_pkg::S_SCAN: begin
                s_ra = r_scan[IW-1:0];
                if (!scan_live) begin
                    n_state = lob_pkg::S_SCAN_END;
                end
            end
            lob_pkg::S_SCAN_END: begin
                case (r_cmd)
                    lob_pkg::CMD_ADD: begin
                        if (!r_ffound || r_match) begin
                            n_state = lob_pkg::S_RPT_BL;
                        end else begin
                            n_state = lob_pkg::S_ADD_RD;
                        end
                    end
                    lob_pkg::CMD_REMOVE: begin
                        n_state = r_match ? lob_pkg::S_RM_RP : lob_pkg::S_RPT_BL;
                    end
                    default: begin
                        n_state = lob_pkg::S_RPT_BL;
                    end
                endcase
            end
            lob_pkg::S_ADD_RD: begin
                l_ra    = {r_side, r_lvl};
                n_state = lob_pkg::S_ADD_WR;
            end
            lob_pkg::S_ADD_WR: begin
                l_we = 1'b1;
                l_wa = {r_side, r_lvl};
                s_we = 1'b1;
                s_wa = r_free;
                if (add_fresh) begin
                    l_wd    = {1'b1, SW'(r_free), SW'(r_free)};
                    s_wd    = {r_id, r_lvl, r_qty, r_side, NO_SLOT, NO_SLOT};
                    n_state = lob_pkg::S_RPT_BL;
                end else begin
                    l_wd    = {1'b1, l_head, SW'(r_free)};
                    s_wd    = {r_id, r_lvl, r_qty, r_side, NO_SLOT, l_tail};
                    n_state = lob_pkg::S_ADD_RT;
                end
            end
            lob_pkg::S_ADD_RT: begin
                s_ra    = r_t;
                n_state = lob_pkg::S_ADD_WT;
            end
            lob_pkg::S_ADD_WT: begin
                // old tail now points at the new order
                s_we    = 1'b1;
                s_wa    = r_t;
                s_wd    = {s_rd[SLW-1:SIDE_B], SW'(r_free), s_rd[NXT_LO-1:0]};
                n_state = lob_pkg::S_RPT_BL;
            end
            lob_pkg::S_RM_RP: begin
                s_ra    = m_prv[IW-1:0];
                n_state = (m_prv < NO_SLOT) ? lob_pkg::S_RM_WP : lob_pkg::S_RM_RN;
            end
            lob_pkg::S_RM_WP: begin
                s_we    = 1'b1;
                s_wa    = m_prv[IW-1:0];
                s_wd    = {s_rd[SLW-1:SIDE_B], m_nxt, s_rd[NXT_LO-1:0]};
                n_state = lob_pkg::S_RM_RN;
            end
            lob_pkg::S_RM_RN: begin
                s_ra    = m_nxt[IW-1:0];
                n_state = (m_nxt < NO_SLOT) ? lob_pkg::S_RM_WN : lob_pkg::S_RM_RL;
            end
            lob_pkg::S_RM_WN: begin
                s_we    = 1'b1;
                s_wa    = m_nxt[IW-1:0];
                s_wd    = {s_rd[SLW-1:NXT_LO], m_prv};
                n_state = lob_pkg::S_RM_RL;
            end
            lob_pkg::S_RM_RL: begin
                l_ra    = {m_side, m_lvl};
                n_state = lob_pkg::S_RM_WL;
            end
            lob_pkg::S_RM_WL: begin
                l_we = 1'b1;
                l_wa = {m_side, m_lvl};
                if (rm_empty) begin
                    l_wd = {1'b0, NO_SLOT, NO_SLOT};
                end else begin
                    l_wd = {l_act, rm_head, rm_tail};
                end
                n_state = lob_pkg::S_RPT_BL;
                // emptied the best level: walk to the next active one
                if (rm_empty && !m_side && r_bl == m_lvl && m_lvl != ZERO_LVL) begin
                    n_state = lob_pkg::S_SRCH_RD;
                end
                if (rm_empty && m_side && r_al == m_lvl && m_lvl != TOP_LVL) begin
                    n_state = lob_pkg::S_SRCH_RD;
                end
            end
            lob_pkg::S_SRCH_RD: begin
                l_ra    = {m_side, r_sidx};
                n_state = lob_pkg::S_SRCH_CK;
            end
            lob_pkg::S_SRCH_CK: begin
                if (l_act) begin
                    n_state = lob_pkg::S_RPT_BL;
                end else if ((!m_side && r_sidx == ZERO_LVL) ||
                             (m_side && r_sidx == TOP_LVL)) begin
                    n_state = lob_pkg::S_RPT_BL;
                end else begin
                    n_state = lob_pkg::S_SRCH_RD;
                end
            end
            lob_pkg::S_RPT_BL: begin
                l_ra    = {1'b0, r_bl};
                n_state = lob_pkg::S_RPT_BS;
            end
            lob_pkg::S_RPT_BS: begin
                s_ra    = l_head[IW-1:0];
                n_state = lob_pkg::S_RPT_AL;
            end
            lob_pkg::S_RPT_AL: begin
                l_ra    = {1'b1, r_al};
                n_state = lob_pkg::S_RPT_AS;
            end
            lob_pkg::S_RPT_AS: begin
                s_ra    = l_head[IW-1:0];
                n_state = lob_pkg::S_RPT_CAP;
            end
            lob_pkg::S_RPT_CAP: begin
                n_state = lob_pkg::S_OUT;
            end
            lob_pkg::S_OUT: begin
                if (i_ready) begin
                    n_state = lob_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lob_pkg::S_IDLE;
            end
        endcase
    end

    // control registers with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo     <= '0;
            r_hi     <= DW'(1023);
            r_clr    <= '0;
            r_in_use <= '0;
            r_bv     <= 1'b0;
            r_av     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lob_pkg::CFG_LOWEST:  r_lo <= i_cfg_data;
                    lob_pkg::CFG_HIGHEST: r_hi <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                lob_pkg::S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                end
                lob_pkg::S_ADD_WR: begin
                    r_in_use[r_free] <= 1'b1;
                    if (!r_side && (!r_bv || r_lvl > r_bl)) begin
                        r_bv <= 1'b1;
                        r_bl <= r_lvl;
                    end
                    if (r_side && (!r_av || r_lvl < r_al)) begin
                        r_av <= 1'b1;
                        r_al <= r_lvl;
                    end
                end
                lob_pkg::S_RM_WL: begin
                    r_in_use[r_ms] <= 1'b0;
                    if (rm_empty && !m_side && r_bl == m_lvl) begin
                        if (m_lvl == ZERO_LVL) begin
                            r_bv <= 1'b0;
                        end
                        r_sidx <= m_lvl - 1'b1;
                    end
                    if (rm_empty && m_side && r_al == m_lvl) begin
                        if (m_lvl == TOP_LVL) begin
                            r_av <= 1'b0;
                        end
                        r_sidx <= m_lvl + 1'b1;
                    end
                end
                lob_pkg::S_SRCH_CK: begin
                    if (l_act) begin
                        if (m_side) begin
                            r_al <= r_sidx;
                        end else begin
                            r_bl <= r_sidx;
                        end
                    end else if (!m_side && r_sidx == ZERO_LVL) begin
                        r_bv <= 1'b0;
                    end else if (m_side && r_sidx == TOP_LVL) begin
                        r_av <= 1'b0;
                    end else if (m_side) begin
                        r_sidx <= r_sidx + 1'b1;
                    end else begin
                        r_sidx <= r_sidx - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            lob_pkg::S_IDLE: begin
                r_cmd    <= i_cmd;
                r_id     <= i_order_id;
                r_price  <= i_order_price;
                r_qty    <= i_order_qty;
                r_side   <= i_order_side;
                r_scan   <= '0;
                r_scan_v <= 1'b0;
                r_ffound <= 1'b0;
                r_match  <= 1'b0;
                r_status <= lob_pkg::ST_OK;
            end
            lob_pkg::S_CHK: begin
                r_lvl <= price_off[LW-1:0];
                if (r_cmd == lob_pkg::CMD_ADD && !in_range) begin
                    r_status <= lob_pkg::ST_RANGE;
                end
            end
            lob_pkg::S_SCAN: begin
                // read issued for r_scan, compare data of the previous slot
                if (scan_live) begin
                    r_scan <= r_scan + 1'b1;
                    if (!r_ffound && !r_in_use[r_scan[IW-1:0]]) begin
                        r_ffound <= 1'b1;
                        r_free   <= r_scan[IW-1:0];
                    end
                end
                r_scan_d <= r_scan;
                r_scan_v <= scan_live;
                if (r_scan_v && r_in_use[r_scan_d[IW-1:0]] && s_rd[SLW-1:ID_LO] == r_id) begin
                    r_match <= 1'b1;
                    r_ms    <= r_scan_d[IW-1:0];
                    r_m     <= s_rd;
                end
            end
            lob_pkg::S_SCAN_END: begin
                case (r_cmd)
                    lob_pkg::CMD_ADD: begin
                        if (!r_ffound) begin
                            r_status <= lob_pkg::ST_FULL;
                        end else if (r_match) begin
                            r_status <= lob_pkg::ST_DUP;
                        end
                    end
                    default: begin
                        if (!r_match) begin
                            r_status <= lob_pkg::ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            lob_pkg::S_ADD_WR: begin
                r_t <= l_tail[IW-1:0];
            end
            lob_pkg::S_RPT_AL: begin
                r_bid_id  <= s_rd[SLW-1:ID_LO];
                r_bid_qty <= s_rd[LVL_LO-1:QTY_LO];
            end
            lob_pkg::S_RPT_CAP: begin
                r_o_status <= r_status;
                r_o_bv     <= r_bv;
                r_o_bp     <= r_bv ? r_lo + DW'(r_bl) : '0;
                r_o_bi     <= r_bv ? r_bid_id : '0;
                r_o_bq     <= r_bv ? r_bid_qty : '0;
                r_o_av     <= r_av;
                r_o_ap     <= r_av ? r_lo + DW'(r_al) : '0;
                r_o_ai     <= r_av ? s_rd[SLW-1:ID_LO] : '0;
                r_o_aq     <= r_av ? s_rd[LVL_LO-1:QTY_LO] : '0;
                if (r_cmd == lob_pkg::CMD_LOOKUP && r_match) begin
                    r_o_fs <= m_side;
                    r_o_fp <= r_lo + DW'(m_lvl);
                    r_o_fq <= m_qty;
                end else begin
                    r_o_fs <= 1'b0;
                    r_o_fp <= '0;
                    r_o_fq <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_status      = r_o_status;
    assign o_bid_valid   = r_o_bv;
    assign o_bid_price   = r_o_bp;
    assign o_bid_id      = r_o_bi;
    assign o_bid_qty     = r_o_bq;
    assign o_ask_valid   = r_o_av;
    assign o_ask_price   = r_o_ap;
    assign o_ask_id      = r_o_ai;
    assign o_ask_qty     = r_o_aq;
    assign o_found_side  = r_o_fs;
    assign o_found_price = r_o_fp;
    assign o_found_qty   = r_o_fq;

endmodule
